### rtl/core/servo_move_settle_tracker_defines.svh
// ----------------------------------------------------------------------------
// servo_move_settle_tracker_defines.svh
// Assertion macros shared by the tracker RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SERVO_MOVE_SETTLE_TRACKER_DEFINES_SVH
`define SERVO_MOVE_SETTLE_TRACKER_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SMST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smst assertion failed");
// antecedent implies consequent in the next cycle
`define SMST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smst assertion failed");
`else
`define SMST_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SMST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/smst_pkg.sv
// ----------------------------------------------------------------------------
// smst_pkg
// Shared widths, codes, reset values and divider interface types.
// ----------------------------------------------------------------------------
package smst_pkg;

    localparam int ANGLE_W   = 16;
    localparam int SPEED_W   = 17;
    localparam int SLOT_W    = 8;
    localparam int OP_W      = 2;
    localparam int ELAPSED_W = 32;
    localparam int SETTLE_W  = 20;   // max quotient 655350 + margin 65535
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // divider: numerator delta*2000 + speed < 2^27, denominator 2*speed
    localparam int NUM_W = 27;
    localparam int DEN_W = SPEED_W + 1;
    localparam int CNT_W = $clog2(NUM_W);

    localparam int MS_SCALE = 2000;  // 2 * 1000 ms/s, rounding done by +speed

    localparam logic [ANGLE_W-1:0] MIN_ANGLE   = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] MAX_ANGLE   = ANGLE_W'(27000);
    localparam logic [SPEED_W-1:0] SPEED_FLOOR = SPEED_W'(100);

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_GOTO_ANGLE = 2'd1,
        OP_GOTO_SLOT  = 2'd2,
        OP_GOTO_PICK  = 2'd3
    } op_t;

    localparam logic [SLOT_W-1:0] SLOT_ONE   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_TWO   = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_THREE = SLOT_W'(3);

    // register map, byte address = 4 * index
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PICK       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_ONE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_TWO   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_THREE = 3'd7;

    localparam logic [ANGLE_W-1:0] RST_TOLERANCE  = ANGLE_W'(100);
    localparam logic [SPEED_W-1:0] RST_SPEED      = SPEED_W'(18000);
    localparam logic [ANGLE_W-1:0] RST_MARGIN     = ANGLE_W'(100);
    localparam logic [ANGLE_W-1:0] RST_DEFAULT    = ANGLE_W'(13500);
    localparam logic [ANGLE_W-1:0] RST_PICK       = ANGLE_W'(13500);
    localparam logic [ANGLE_W-1:0] RST_SLOT_ONE   = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] RST_SLOT_TWO   = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] RST_SLOT_THREE = ANGLE_W'(27000);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

### rtl/core/servo_move_settle_tracker.sv
// ----------------------------------------------------------------------------
// servo_move_settle_tracker
// Servo move-and-settle tracker: ticks advance a ms timer, commands set a
// target and a settle estimate computed by a shared serial divider.
// Sequence: a tick runs PREP, FIN; a command that keeps its target runs PREP,
//   CHK, CMP, FIN; one that drives adds MUL, DIV (27-step divider) before FIN.
// FIN waits while a result is unclaimed; s_ready only while idle.
// Reset: aresetn synchronous active low; registers to documented defaults,
//   tracker uninitialised, timer and settle time zero.
// ----------------------------------------------------------------------------
`include "servo_move_settle_tracker_defines.svh"

module servo_move_settle_tracker
    import smst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // item input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_op,
    input  logic [ANGLE_W-1:0] s_angle,
    input  logic [SLOT_W-1:0]  s_slot,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_arrived,
    output logic [ANGLE_W-1:0] m_current_angle,
    output logic [ANGLE_W-1:0] m_target_angle,
    output logic               m_drive_valid,
    output logic [ANGLE_W-1:0] m_drive_angle
);

    // Sequencer: PREP resolves the target and handles first-command init or
    // the tick; CHK does the mid-command arrival check; CMP tests tolerance;
    // MUL launches the divide; DIV waits on it; FIN does the final arrival
    // check and loads the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHK,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    // ---------------- configuration registers ----------------
    logic [ANGLE_W-1:0] tol_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [ANGLE_W-1:0] margin_reg;
    logic [ANGLE_W-1:0] default_reg;
    logic [ANGLE_W-1:0] pick_reg;
    logic [ANGLE_W-1:0] slot_one_reg;
    logic [ANGLE_W-1:0] slot_two_reg;
    logic [ANGLE_W-1:0] slot_three_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg        <= RST_TOLERANCE;
            speed_reg      <= RST_SPEED;
            margin_reg     <= RST_MARGIN;
            default_reg    <= RST_DEFAULT;
            pick_reg       <= RST_PICK;
            slot_one_reg   <= RST_SLOT_ONE;
            slot_two_reg   <= RST_SLOT_TWO;
            slot_three_reg <= RST_SLOT_THREE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TOLERANCE:  tol_reg        <= pwdata[ANGLE_W-1:0];
                REG_SPEED:      speed_reg      <= pwdata[SPEED_W-1:0];
                REG_MARGIN:     margin_reg     <= pwdata[ANGLE_W-1:0];
                REG_DEFAULT:    default_reg    <= pwdata[ANGLE_W-1:0];
                REG_PICK:       pick_reg       <= pwdata[ANGLE_W-1:0];
                REG_SLOT_ONE:   slot_one_reg   <= pwdata[ANGLE_W-1:0];
                REG_SLOT_TWO:   slot_two_reg   <= pwdata[ANGLE_W-1:0];
                REG_SLOT_THREE: slot_three_reg <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TOLERANCE:  prdata = PDATA_W'(tol_reg);
            REG_SPEED:      prdata = PDATA_W'(speed_reg);
            REG_MARGIN:     prdata = PDATA_W'(margin_reg);
            REG_DEFAULT:    prdata = PDATA_W'(default_reg);
            REG_PICK:       prdata = PDATA_W'(pick_reg);
            REG_SLOT_ONE:   prdata = PDATA_W'(slot_one_reg);
            REG_SLOT_TWO:   prdata = PDATA_W'(slot_two_reg);
            REG_SLOT_THREE: prdata = PDATA_W'(slot_three_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- helpers ----------------
    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] r;
        r = a;
        if (a < MIN_ANGLE) begin
            r = MIN_ANGLE;
        end else if (a > MAX_ANGLE) begin
            r = MAX_ANGLE;
        end
        return r;
    endfunction

    function automatic logic [ANGLE_W-1:0] abs_diff(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // ---------------- tracker state and sequencer ----------------
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ANGLE_W-1:0]  angle_in_reg, angle_in_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ANGLE_W-1:0]  tgt_reg, tgt_next;
    logic [ANGLE_W-1:0]  delta_reg, delta_next;
    logic                init_reg, init_next;
    logic [ANGLE_W-1:0]  present_reg, present_next;
    logic [ANGLE_W-1:0]  goal_reg, goal_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic                drove_reg, drove_next;
    logic [ANGLE_W-1:0]  drive_reg, drive_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_arrived_reg, m_arrived_next;
    logic [ANGLE_W-1:0]  m_cur_reg, m_cur_next;
    logic [ANGLE_W-1:0]  m_tgt_reg, m_tgt_next;
    logic                m_drove_reg, m_drove_next;
    logic [ANGLE_W-1:0]  m_drive_reg, m_drive_next;

    logic [ANGLE_W-1:0]  req_angle;
    logic [SPEED_W-1:0]  speed_eff;
    logic                settled;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // requested angle before clamping
    always_comb begin
        case (op_reg)
            OP_GOTO_ANGLE: req_angle = angle_in_reg;
            OP_GOTO_PICK:  req_angle = pick_reg;
            OP_GOTO_SLOT: begin
                if (slot_reg == SLOT_ONE) begin
                    req_angle = slot_one_reg;
                end else if (slot_reg == SLOT_TWO) begin
                    req_angle = slot_two_reg;
                end else if (slot_reg == SLOT_THREE) begin
                    req_angle = slot_three_reg;
                end else begin
                    req_angle = default_reg;
                end
            end
            default:       req_angle = default_reg;
        endcase
    end

    assign speed_eff = (speed_reg < SPEED_FLOOR) ? SPEED_FLOOR : speed_reg;
    assign settled   = (elapsed_reg >= ELAPSED_W'(settle_reg));

    // travel time = (delta*2000 + speed) / (2*speed), rounded half up
    assign div_req.start = (state_reg == ST_MUL);
    assign div_req.num   = NUM_W'(delta_reg) * NUM_W'(MS_SCALE) + NUM_W'(speed_eff);
    assign div_req.den   = {speed_eff, 1'b0};

    smst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        angle_in_next  = angle_in_reg;
        slot_next      = slot_reg;
        tgt_next       = tgt_reg;
        delta_next     = delta_reg;
        init_next      = init_reg;
        present_next   = present_reg;
        goal_next      = goal_reg;
        elapsed_next   = elapsed_reg;
        settle_next    = settle_reg;
        drove_next     = drove_reg;
        drive_next     = drive_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_arrived_next = m_arrived_reg;
        m_cur_next     = m_cur_reg;
        m_tgt_next     = m_tgt_reg;
        m_drove_next   = m_drove_reg;
        m_drive_next   = m_drive_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = op_t'(s_op);
                    angle_in_next = s_angle;
                    slot_next     = s_slot;
                    state_next    = ST_PREP;
                end
            end
            ST_PREP: begin
                drove_next = 1'b0;
                drive_next = '0;
                if (op_reg == OP_TICK) begin
                    if (elapsed_reg != '1) begin
                        elapsed_next = elapsed_reg + ELAPSED_W'(1);
                    end
                    state_next = ST_FIN;
                end else begin
                    tgt_next = clamp_angle(req_angle);
                    // first command: start from the default angle, unclamped
                    if (!init_reg) begin
                        init_next    = 1'b1;
                        present_next = default_reg;
                        goal_next    = default_reg;
                        elapsed_next = '0;
                        settle_next  = '0;
                        drove_next   = 1'b1;
                        drive_next   = default_reg;
                    end
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (settled) begin
                    present_next = goal_reg;
                end
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (abs_diff(tgt_reg, goal_reg) > tol_reg) begin
                    delta_next   = abs_diff(present_reg, tgt_reg);
                    goal_next    = tgt_reg;
                    elapsed_next = '0;
                    drove_next   = 1'b1;
                    drive_next   = tgt_reg;
                    state_next   = ST_MUL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    settle_next = div_rsp.quot[SETTLE_W-1:0] + SETTLE_W'(margin_reg);
                    state_next  = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold here while the previous result is still unclaimed
                if (!m_valid_reg || m_ready) begin
                    if (init_reg && settled) begin
                        present_next = goal_reg;
                    end
                    m_valid_next   = 1'b1;
                    m_arrived_next = init_reg & settled;
                    m_cur_next     = (init_reg && settled) ? goal_reg : present_reg;
                    m_tgt_next     = goal_reg;
                    m_drove_next   = drove_reg;
                    m_drive_next   = drive_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            init_reg    <= 1'b0;
            present_reg <= '0;
            goal_reg    <= '0;
            elapsed_reg <= '0;
            settle_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            angle_in_reg  <= angle_in_next;
            slot_reg      <= slot_next;
            tgt_reg       <= tgt_next;
            delta_reg     <= delta_next;
            init_reg      <= init_next;
            present_reg   <= present_next;
            goal_reg      <= goal_next;
            elapsed_reg   <= elapsed_next;
            settle_reg    <= settle_next;
            drove_reg     <= drove_next;
            drive_reg     <= drive_next;
            m_valid_reg   <= m_valid_next;
            m_arrived_reg <= m_arrived_next;
            m_cur_reg     <= m_cur_next;
            m_tgt_reg     <= m_tgt_next;
            m_drove_reg   <= m_drove_next;
            m_drive_reg   <= m_drive_next;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_arrived       = m_arrived_reg;
    assign m_current_angle = m_cur_reg;
    assign m_target_angle  = m_tgt_reg;
    assign m_drive_valid   = m_drove_reg;
    assign m_drive_angle   = m_drive_reg;

    // ---------------- assertions ----------------
    // the believed angle only ever moves onto the goal
    `SMST_ASSERT_IMPL(a_present_to_goal, aclk, aresetn, !$stable(present_reg), present_reg == goal_reg)
    // an arrived result reports current equal to target
    `SMST_ASSERT_IMPL(a_arrived_match, aclk, aresetn, m_valid && m_arrived, m_current_angle == m_target_angle)
    // no drive reported means the drive angle is zero
    `SMST_ASSERT_IMPL(a_drive_zero, aclk, aresetn, m_valid && !m_drive_valid, m_drive_angle == '0)
    // divider completes only while the sequencer waits for it
    `SMST_ASSERT_IMPL(a_div_done_wait, aclk, aresetn, div_rsp.done, state_reg == ST_DIV)
    // a divide launch always lands in the wait state
    `SMST_ASSERT_NEXT(a_div_launch, aclk, aresetn, state_reg == ST_MUL, state_reg == ST_DIV)

endmodule

### rtl/core/smst_div.sv
// ----------------------------------------------------------------------------
// smst_div
// Restoring divider, one quotient bit per cycle, NUM_W bits per divide.
// ----------------------------------------------------------------------------
module smst_div
    import smst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

### dv/servo_move_settle_tracker_test.sv
// ----------------------------------------------------------------------------
// servo_move_settle_tracker_test
// Self-checking bench for the servo move-and-settle tracker. Items are
// checked against a tracker model, typed rows against a hand-typed report.
// Directed table first; then random phases, new settings and idle patterns.
// ----------------------------------------------------------------------------
module servo_move_settle_tracker_test;
    import smst_pkg::*;

    // one report per item, in port order
    typedef struct packed {
        logic               arrived;
        logic [ANGLE_W-1:0] current;
        logic [ANGLE_W-1:0] target;
        logic               drive;
        logic [ANGLE_W-1:0] drive_angle;
    } report_t;

    // directed row: typed marks rows whose report is written out by hand
    typedef struct packed {
        op_t                op;
        logic [ANGLE_W-1:0] angle;
        logic [SLOT_W-1:0]  slot;
        logic               typed;
        report_t            want;
    } stim_row_t;

    localparam int DIRECTED_N = 21;
    localparam int WAIT_TAIL  = 40;    // longest item latency plus slack
    localparam report_t NO_REPORT = '0;

    // Runs right after reset with register defaults: tolerance 100,
    // speed 180 deg/s, margin 100 ms, default and pick 135 deg,
    // slots 0 / 0 / 270 deg.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // ticks before the first command: timer counts, report stays zero
        '{OP_TICK,       16'd0,     8'd0,   1'b1, NO_REPORT},
        '{OP_TICK,       16'hFFFF,  8'hFF,  1'b1, NO_REPORT},
        // first command also drives: only its own angle is reported;
        // 65535 clamps to 27000, settle 750 + 100 ms
        '{OP_GOTO_ANGLE, 16'hFFFF,  8'd0,   1'b1,
          '{1'b0, 16'd13500, 16'd27000, 1'b1, 16'd27000}},
        '{OP_TICK,       16'd0,     8'd0,   1'b0, NO_REPORT},
        // slot three equals the target: ignored
        '{OP_GOTO_SLOT,  16'd0,     8'd3,   1'b0, NO_REPORT},
        // clamped to the same target: ignored
        '{OP_GOTO_ANGLE, 16'd27101, 8'd0,   1'b0, NO_REPORT},
        // change of exactly the tolerance is ignored, one more drives
        '{OP_GOTO_ANGLE, 16'd26900, 8'd0,   1'b0, NO_REPORT},
        '{OP_GOTO_ANGLE, 16'd26899, 8'd0,   1'b0, NO_REPORT},
        '{OP_TICK,       16'd1234,  8'd7,   1'b0, NO_REPORT},
        '{OP_GOTO_PICK,  16'd500,   8'd9,   1'b0, NO_REPORT},
        '{OP_GOTO_SLOT,  16'd0,     8'd1,   1'b0, NO_REPORT},
        '{OP_GOTO_SLOT,  16'd0,     8'd2,   1'b0, NO_REPORT},
        // unknown slots fall back to the default place angle
        '{OP_GOTO_SLOT,  16'd0,     8'd0,   1'b0, NO_REPORT},
        '{OP_GOTO_SLOT,  16'd0,     8'd255, 1'b0, NO_REPORT},
        '{OP_GOTO_ANGLE, 16'd0,     8'd0,   1'b0, NO_REPORT},
        '{OP_GOTO_SLOT,  16'hFFFF,  8'd4,   1'b0, NO_REPORT},
        '{OP_GOTO_ANGLE, 16'd36000, 8'd0,   1'b0, NO_REPORT},
        '{OP_TICK,       16'd0,     8'd0,   1'b0, NO_REPORT},
        '{OP_GOTO_ANGLE, 16'd80,    8'd0,   1'b0, NO_REPORT},
        '{OP_GOTO_SLOT,  16'd0,     8'd3,   1'b0, NO_REPORT},
        '{OP_TICK,       16'd0,     8'd0,   1'b0, NO_REPORT}
    };

    localparam int PHASES = 8;
    localparam int PHASE_ITEMS [PHASES] = '{200, 100, 180, 200, 200, 200, 190, 180};

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_op;
    logic [ANGLE_W-1:0] s_angle;
    logic [SLOT_W-1:0]  s_slot;
    logic               m_valid;
    logic               m_ready;
    logic               m_arrived;
    logic [ANGLE_W-1:0] m_current_angle;
    logic [ANGLE_W-1:0] m_target_angle;
    logic               m_drive_valid;
    logic [ANGLE_W-1:0] m_drive_angle;

    servo_move_settle_tracker dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_angle         (s_angle),
        .s_slot          (s_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_arrived       (m_arrived),
        .m_current_angle (m_current_angle),
        .m_target_angle  (m_target_angle),
        .m_drive_valid   (m_drive_valid),
        .m_drive_angle   (m_drive_angle)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Tracker model: registers and state as the block should hold them
    // ------------------------------------------------------------------------
    logic [ANGLE_W-1:0] tol_cfg;
    logic [SPEED_W-1:0] speed_cfg;
    logic [ANGLE_W-1:0] margin_cfg;
    logic [ANGLE_W-1:0] default_cfg;
    logic [ANGLE_W-1:0] pick_cfg;
    logic [ANGLE_W-1:0] slot_cfg [1:3];

    logic               tracker_live;
    logic [ANGLE_W-1:0] believed_angle;
    logic [ANGLE_W-1:0] goal_angle;
    logic [31:0]        elapsed_ms;
    logic [31:0]        settle_limit;

    report_t due_reports [$];   // reports still owed by the block
    int      fail_count;
    int      send_gap_pct;      // chance per cycle that the sender idles
    int      stall_pct;         // chance per cycle that m_ready is low

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
        if (a < MIN_ANGLE) return MIN_ANGLE;   // lower bound is tested first
        if (a > MAX_ANGLE) return MAX_ANGLE;
        return a;
    endfunction

    function automatic int unsigned angle_gap(input logic [ANGLE_W-1:0] a,
                                              input logic [ANGLE_W-1:0] b);
        return (a >= b) ? int'(a - b) : int'(b - a);
    endfunction

    // travel time in ms, rounded half up, plus margin; speed floored
    function automatic logic [31:0] settle_estimate(input logic [ANGLE_W-1:0] from,
                                                    input logic [ANGLE_W-1:0] to);
        longint unsigned delta;
        longint unsigned spd;
        longint unsigned q;
        delta = angle_gap(from, to);
        spd   = speed_cfg;
        if (spd < SPEED_FLOOR) spd = SPEED_FLOOR;
        q = (delta * 2000 + spd) / (2 * spd);
        return 32'(q + margin_cfg);
    endfunction

    // arrival also snaps the believed angle onto the goal
    function automatic logic check_settled();
        if (!tracker_live) return 1'b0;
        if (elapsed_ms >= settle_limit) begin
            believed_angle = goal_angle;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic report_t predict_report(input op_t op,
                                               input logic [ANGLE_W-1:0] angle,
                                               input logic [SLOT_W-1:0] slot);
        report_t            r;
        logic [ANGLE_W-1:0] req;
        logic [ANGLE_W-1:0] tgt;
        r = '0;
        if (op == OP_TICK) begin
            if (elapsed_ms != 32'hFFFF_FFFF) elapsed_ms = elapsed_ms + 32'd1;
        end else begin
            case (op)
                OP_GOTO_ANGLE: req = angle;
                OP_GOTO_PICK:  req = pick_cfg;
                default: begin
                    if (slot >= SLOT_ONE && slot <= SLOT_THREE) req = slot_cfg[slot[1:0]];
                    else req = default_cfg;
                end
            endcase
            tgt = clamp_angle(req);
            // first command: power-on angle, unclamped, driven first
            if (!tracker_live) begin
                believed_angle = default_cfg;
                goal_angle     = default_cfg;
                elapsed_ms     = '0;
                settle_limit   = '0;
                tracker_live   = 1'b1;
                r.drive        = 1'b1;
                r.drive_angle  = default_cfg;
            end
            void'(check_settled());
            if (angle_gap(tgt, goal_angle) > tol_cfg) begin
                settle_limit  = settle_estimate(believed_angle, tgt);
                goal_angle    = tgt;
                elapsed_ms    = '0;
                r.drive       = 1'b1;
                r.drive_angle = tgt;
            end
        end
        r.arrived = check_settled();
        r.current = believed_angle;
        r.target  = goal_angle;
        return r;
    endfunction

    task automatic reset_model();
        tol_cfg        = RST_TOLERANCE;
        speed_cfg      = RST_SPEED;
        margin_cfg     = RST_MARGIN;
        default_cfg    = RST_DEFAULT;
        pick_cfg       = RST_PICK;
        slot_cfg[1]    = RST_SLOT_ONE;
        slot_cfg[2]    = RST_SLOT_TWO;
        slot_cfg[3]    = RST_SLOT_THREE;
        tracker_live   = 1'b0;
        believed_angle = '0;
        goal_angle     = '0;
        elapsed_ms     = '0;
        settle_limit   = '0;
    endtask

    // ------------------------------------------------------------------------
    // Register writes: setup then access, called at a falling edge;
    // then the bus idles with psel low so back-to-back writes never collide
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOLERANCE:  tol_cfg     = value[ANGLE_W-1:0];
            REG_SPEED:      speed_cfg   = value[SPEED_W-1:0];
            REG_MARGIN:     margin_cfg  = value[ANGLE_W-1:0];
            REG_DEFAULT:    default_cfg = value[ANGLE_W-1:0];
            REG_PICK:       pick_cfg    = value[ANGLE_W-1:0];
            REG_SLOT_ONE:   slot_cfg[1] = value[ANGLE_W-1:0];
            REG_SLOT_TWO:   slot_cfg[2] = value[ANGLE_W-1:0];
            REG_SLOT_THREE: slot_cfg[3] = value[ANGLE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic program_tracker(input int tol, input int speed, input int margin,
                                   input int dflt, input int pick,
                                   input int s1, input int s2, input int s3);
        write_register(REG_TOLERANCE,  PDATA_W'(tol));
        write_register(REG_SPEED,      PDATA_W'(speed));
        write_register(REG_MARGIN,     PDATA_W'(margin));
        write_register(REG_DEFAULT,    PDATA_W'(dflt));
        write_register(REG_PICK,       PDATA_W'(pick));
        write_register(REG_SLOT_ONE,   PDATA_W'(s1));
        write_register(REG_SLOT_TWO,   PDATA_W'(s2));
        write_register(REG_SLOT_THREE, PDATA_W'(s3));
    endtask

    // settings per phase; the first four pin the extremes
    task automatic program_phase(input int phase);
        case (phase)
            0: program_tracker(0, 100000, 0, 0, 36000, 36000, 1, 13500);
            1: program_tracker(36000, 0, 65535, 65535, 0, 0, 65535, 27000);
            2: program_tracker(50, 99, 3, 27000, 20000, 5000, 9000, 27001);
            3: program_tracker(1, 131071, 1, 36000, 100, 26999, 27000, 0);
            default: program_tracker($urandom_range(0, 400), $urandom_range(30000, 131071),
                                     $urandom_range(0, 30), $urandom_range(0, 36000),
                                     $urandom_range(0, 36000), $urandom_range(0, 36000),
                                     $urandom_range(0, 36000), $urandom_range(0, 36000));
        endcase
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 49; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 49; end
            default: begin send_gap_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Item sender; entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input op_t op, input logic [ANGLE_W-1:0] angle,
                             input logic [SLOT_W-1:0] slot,
                             input logic typed, input report_t want);
        report_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        // model runs on every item so its state tracks the block;
        // hand-typed rows override the expectation
        predicted = predict_report(op, angle, slot);
        due_reports.push_back(typed ? want : predicted);
        s_valid <= 1'b1;
        s_op    <= op;
        s_angle <= angle;
        s_slot  <= slot;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // stop sending and wait for every owed report, then let the block settle
    task automatic wait_reports_drained();
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (WAIT_TAIL) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly ticks so that settles complete; the commonest move lands near the
    // present goal, which keeps settle times short enough to be reached.
    task automatic random_item();
        int                 sel;
        int                 near;
        op_t                op;
        logic [ANGLE_W-1:0] angle;
        logic [SLOT_W-1:0]  slot;
        sel   = $urandom_range(0, 99);
        angle = ANGLE_W'($urandom_range(0, 65535));
        slot  = SLOT_W'($urandom_range(0, 255));
        if (sel < 68) begin
            op = OP_TICK;
        end else if (sel < 82) begin
            op   = OP_GOTO_ANGLE;
            near = int'(goal_angle) + int'($urandom_range(0, 5000)) - 2500;
            if (near < 0) near = 0;
            angle = ANGLE_W'(near);
        end else if (sel < 87) begin
            op = OP_GOTO_ANGLE;
        end else if (sel < 94) begin
            op = OP_GOTO_SLOT;
            if ($urandom_range(0, 3) != 0) slot = SLOT_W'($urandom_range(0, 3));
        end else begin
            op = OP_GOTO_PICK;
        end
        send_item(op, angle, slot, 1'b0, NO_REPORT);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls on m_ready
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic note_failure(input string what, input report_t want, input report_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected arr=%0d cur=%0d tgt=%0d drv=%0d dang=%0d,",
                     $realtime, what, want.arrived, want.current, want.target,
                     want.drive, want.drive_angle,
                     " got arr=%0d cur=%0d tgt=%0d drv=%0d dang=%0d",
                     got.arrived, got.current, got.target, got.drive, got.drive_angle);
    endtask

    // compare each report with the oldest one owed
    always @(posedge aclk) begin : report_check
        report_t got;
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_arrived, m_current_angle, m_target_angle, m_drive_valid, m_drive_angle};
            if (due_reports.size() == 0) begin
                note_failure("unexpected report", NO_REPORT, got);
            end else begin
                want = due_reports.pop_front();
                if (got.arrived !== want.arrived || got.current !== want.current ||
                    got.target !== want.target || got.drive !== want.drive ||
                    got.drive_angle !== want.drive_angle)
                    note_failure("report mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_op         = OP_TICK;
        s_angle      = '0;
        s_slot       = '0;
        m_ready      = 1'b0;
        fail_count   = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        reset_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table at reset defaults, no idling
        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].angle, DIRECTED_ROWS[i].slot,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // random phases: registers rewritten only once the block is idle
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_reports_drained();
            program_phase(phase);
            set_idle_mode(phase % 4);
            for (int n = 0; n < PHASE_ITEMS[phase]; n++) begin
                // hold the sender until the block has fully caught up
                if (phase == 0 && n == 100) wait_reports_drained();
                random_item();
            end
        end

        wait_reports_drained();
        if (fail_count == 0 && due_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
